/* rtl/mcm_pkg.sv */
// Shared types and constants for the matrix chain minimum cost block.
// No dependencies.
`default_nettype none
package mcm_pkg;

   localparam int COST_W = 56;
   localparam int SUM_W  = 58;
   localparam int FIELD_W = 16;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_IV,
      ST_IV2,
      ST_RD,
      ST_MUL1,
      ST_MUL2,
      ST_ACC,
      ST_WR,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic start;
      logic ld_ends;
      logic mul1;
      logic mul2;
      logic acc;
      logic zero_a;
      logic zero_b;
   } mac_ctrl_type;

endpackage
`default_nettype wire

/* rtl/mcm_dim_mem.sv */
// Dimension store: one write port, two registered read ports.
// No package dependencies.
`default_nettype none
module mcm_dim_mem #(
   parameter int DIM_BITS = 16,
   parameter int IW = 4
) (
   input  wire logic                clock,
   input  wire logic                we,
   input  wire logic [IW-1:0]       waddr,
   input  wire logic [DIM_BITS-1:0] wdata,
   input  wire logic [IW-1:0]       raddr_a,
   input  wire logic [IW-1:0]       raddr_b,
   output logic      [DIM_BITS-1:0] rdata_a,
   output logic      [DIM_BITS-1:0] rdata_b
);

   logic [DIM_BITS-1:0] mem [1 << IW];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
   end

endmodule
`default_nettype wire

/* rtl/mcm_cost_mem.sv */
// Interval cost table: one write port, two registered read ports.
// Uses mcm_pkg for the cost width.
`default_nettype none
module mcm_cost_mem
   import mcm_pkg::*;
#(
   parameter int AW = 8
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [AW-1:0]     waddr,
   input  wire logic [COST_W-1:0] wdata,
   input  wire logic [AW-1:0]     raddr_a,
   input  wire logic [AW-1:0]     raddr_b,
   output logic      [COST_W-1:0] rdata_a,
   output logic      [COST_W-1:0] rdata_b
);

   logic [COST_W-1:0] mem [1 << AW];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
   end

endmodule
`default_nettype wire

/* rtl/mcm_mac.sv */
// Shared arithmetic unit: split-term products, cost sum and running minimum.
// Uses mcm_pkg for widths and the control struct.
`default_nettype none
module mcm_mac
   import mcm_pkg::*;
#(
   parameter int DIM_BITS = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire mac_ctrl_type        ctrl,
   input  wire logic [DIM_BITS-1:0] dim_a,
   input  wire logic [DIM_BITS-1:0] dim_b,
   input  wire logic [COST_W-1:0]   cost_a,
   input  wire logic [COST_W-1:0]   cost_b,
   output logic      [COST_W-1:0]   best
);

   localparam int P1W = 2 * DIM_BITS;
   localparam int P2W = 3 * DIM_BITS;

   logic [DIM_BITS-1:0] dlo_ff, dhi_ff;
   logic [P1W-1:0]      p1_ff;
   logic [P2W-1:0]      prod_ff;
   logic [SUM_W-1:0]    csum_ff, best_ff;
   logic                first_ff, first_in;
   logic [SUM_W-1:0]    term_a, term_b, cand;
   logic                take;

   always_comb begin
      term_a = ctrl.zero_a ? '0 : SUM_W'(cost_a);
      term_b = ctrl.zero_b ? '0 : SUM_W'(cost_b);
      cand   = csum_ff + SUM_W'(prod_ff);
      take   = first_ff || (cand < best_ff);
      first_in = first_ff;
      if (ctrl.start) begin
         first_in = 1'b1;
      end else if (ctrl.acc) begin
         first_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b1;
      end else begin
         first_ff <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.ld_ends) begin
         dlo_ff <= dim_a;
         dhi_ff <= dim_b;
      end
      if (ctrl.mul1) begin
         p1_ff   <= P1W'(dlo_ff) * P1W'(dim_a);
         csum_ff <= term_a + term_b;
      end
      if (ctrl.mul2) begin
         prod_ff <= P2W'(p1_ff) * P2W'(dhi_ff);
      end
      if (ctrl.acc && take) begin
         best_ff <= cand;
      end
   end

   assign best = best_ff[COST_W-1:0];

endmodule
`default_nettype wire

/* rtl/matrix_chain_min_cost_top.sv */
// Matrix chain minimum cost: sequencer, dimension and cost stores, shared MAC.
// Depends on mcm_pkg, mcm_dim_mem, mcm_cost_mem and mcm_mac.
//
// Usage: send the chain's dimensions on the req_ channel, one per transfer,
// with req_last_dim set on the final one. Only the low DIM_BITS bits of each
// dimension are kept. Dimensions beyond MAX_DIMS are dropped and flag
// rsp_too_many. After the closing transfer the block fills the interval cost
// table and presents one rsp_ transfer carrying the least multiplication count.
// Loading takes one cycle per dimension. For n stored dimensions (n >= 3) the
// fill walks every interval of span 2..n-1; each interval runs setup, then per
// split point a read, two multiplies and an accumulate/compare in the shared
// multiply/add/compare unit, then the write-back of its cost to the table.
// Shorter chains answer with cost 0 in the cycle after the closing transfer.
// req_ready is low from the closing transfer until the result transfer.
// While the receiver stalls the result holds on rsp_ and no input is taken.
// Reset (synchronous) returns to idle and empties the dimension count and the
// overflow flag; the stores themselves need no clearing.
`default_nettype none
module matrix_chain_min_cost_top
   import mcm_pkg::*;
#(
   parameter int MAX_DIMS = 16,
   parameter int DIM_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [FIELD_W-1:0] req_dimension,
   input  wire logic               req_last_dim,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic      [COST_W-1:0]  rsp_min_cost,
   output logic                    rsp_too_many
);

   localparam int IW = $clog2(MAX_DIMS);
   localparam int CW = $clog2(MAX_DIMS + 1);
   localparam int AW = 2 * IW;

   state_type state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              ovf_ff, ovf_in;
   logic [IW-1:0]     lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in, span_ff, span_in;
   logic [COST_W-1:0] cost_ff, cost_in;
   logic              tm_ff, tm_in;

   logic              accept;
   logic              dim_we;
   logic [CW-1:0]     n_new;
   logic              ovf_new;
   mac_ctrl_type      ctrl;
   logic [DIM_BITS-1:0] dim_a, dim_b;
   logic [COST_W-1:0] cost_a, cost_b, best;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_min_cost = cost_ff;
   assign rsp_too_many = tm_ff;
   assign dim_we = accept && (count_ff < CW'(MAX_DIMS));

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      mid_in   = mid_ff;
      span_in  = span_ff;
      cost_in  = cost_ff;
      tm_in    = tm_ff;
      ctrl     = '0;
      n_new    = dim_we ? count_ff + CW'(1) : count_ff;
      ovf_new  = ovf_ff || (accept && !dim_we);
      ctrl.zero_a = (CW'(mid_ff) == CW'(lo_ff) + CW'(1));
      ctrl.zero_b = (CW'(mid_ff) + CW'(1) == CW'(hi_ff));
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               count_in = n_new;
               ovf_in   = ovf_new;
               if (req_last_dim) begin
                  tm_in = ovf_new;
                  if (n_new < CW'(3)) begin
                     cost_in  = '0;
                     state_in = ST_OUT;
                  end else begin
                     span_in  = IW'(2);
                     lo_in    = '0;
                     hi_in    = IW'(2);
                     state_in = ST_IV;
                  end
               end
            end
         end
         ST_IV: begin
            ctrl.start = 1'b1;
            state_in   = ST_IV2;
         end
         ST_IV2: begin
            ctrl.ld_ends = 1'b1;
            mid_in   = lo_ff + IW'(1);
            state_in = ST_RD;
         end
         ST_RD: begin
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            ctrl.mul1 = 1'b1;
            state_in  = ST_MUL2;
         end
         ST_MUL2: begin
            ctrl.mul2 = 1'b1;
            state_in  = ST_ACC;
         end
         ST_ACC: begin
            ctrl.acc = 1'b1;
            if (CW'(mid_ff) + CW'(1) == CW'(hi_ff)) begin
               state_in = ST_WR;
            end else begin
               mid_in   = mid_ff + IW'(1);
               state_in = ST_RD;
            end
         end
         ST_WR: begin
            if (CW'(hi_ff) + CW'(1) < count_ff) begin
               lo_in    = lo_ff + IW'(1);
               hi_in    = hi_ff + IW'(1);
               state_in = ST_IV;
            end else if (CW'(span_ff) + CW'(1) < count_ff) begin
               span_in  = span_ff + IW'(1);
               lo_in    = '0;
               hi_in    = span_ff + IW'(1);
               state_in = ST_IV;
            end else begin
               cost_in  = best;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               count_in = '0;
               ovf_in   = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      mid_ff  <= mid_in;
      span_ff <= span_in;
      cost_ff <= cost_in;
      tm_ff   <= tm_in;
   end

   mcm_dim_mem #(
      .DIM_BITS(DIM_BITS),
      .IW(IW)
   ) u_dim_mem (
      .clock   (clock),
      .we      (dim_we),
      .waddr   (count_ff[IW-1:0]),
      .wdata   (req_dimension[DIM_BITS-1:0]),
      .raddr_a ((state_ff == ST_IV) ? lo_ff : mid_ff),
      .raddr_b (hi_ff),
      .rdata_a (dim_a),
      .rdata_b (dim_b)
   );

   mcm_cost_mem #(
      .AW(AW)
   ) u_cost_mem (
      .clock   (clock),
      .we      (state_ff == ST_WR),
      .waddr   ({lo_ff, hi_ff}),
      .wdata   (best),
      .raddr_a ({lo_ff, mid_ff}),
      .raddr_b ({mid_ff, hi_ff}),
      .rdata_a (cost_a),
      .rdata_b (cost_b)
   );

   mcm_mac #(
      .DIM_BITS(DIM_BITS)
   ) u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .dim_a  (dim_a),
      .dim_b  (dim_b),
      .cost_a (cost_a),
      .cost_b (cost_b),
      .best   (best)
   );

endmodule
`default_nettype wire

/* tb/matrix_chain_min_cost_top_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for matrix_chain_min_cost_top: chains of dimensions in,
// least multiplication count out, checked against an interval-DP predictor.
// Depends on mcm_pkg and the matrix_chain_min_cost_top RTL.
module matrix_chain_min_cost_top_test;
   import mcm_pkg::*;

   localparam int MAX_DIMS    = 16;
   localparam int DIM_BITS    = 16;
   localparam int ITEM_TARGET = 1300;
   localparam int QUIET_ITEMS = 150;
   localparam int MAX_REPORTS = 40;

   typedef struct packed {
      logic [COST_W-1:0] cost;
      logic              too_many;
   } chain_result_type;

   typedef enum {DIMS_SMALL, DIMS_FULL, DIMS_CORNER} dim_style_type;

   logic               clock         = 1'b0;
   logic               reset         = 1'b1;
   logic               req_valid     = 1'b0;
   logic               req_ready;
   logic [FIELD_W-1:0] req_dimension = '0;
   logic               req_last_dim  = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready     = 1'b0;
   logic [COST_W-1:0]  rsp_min_cost;
   logic               rsp_too_many;

   chain_result_type    pending_costs[$];
   logic [DIM_BITS-1:0] model_dims[MAX_DIMS];
   int                  model_count      = 0;
   logic                model_overflow   = 1'b0;
   int                  idle_pct         = 0;
   int                  errors           = 0;
   int                  items_sent       = 0;
   int                  chains_sent      = 0;
   int                  truncated_chains = 0;
   int                  results_seen     = 0;

   matrix_chain_min_cost_top #(
      .MAX_DIMS(MAX_DIMS),
      .DIM_BITS(DIM_BITS)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_dimension(req_dimension),
      .req_last_dim (req_last_dim),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_min_cost (rsp_min_cost),
      .rsp_too_many (rsp_too_many)
   );

   always #5 clock = ~clock;

   function automatic logic [COST_W-1:0] least_mults(int n);
      logic [63:0] span_cost[MAX_DIMS][MAX_DIMS];
      logic [63:0] best;
      logic [63:0] trial;
      if (n < 3) return '0;
      for (int lo = 0; lo + 1 < n; lo++) span_cost[lo][lo+1] = '0;
      for (int span = 2; span < n; span++) begin
         for (int lo = 0; lo + span < n; lo++) begin
            best = '1;
            for (int mid = lo + 1; mid < lo + span; mid++) begin
               trial = span_cost[lo][mid] + span_cost[mid][lo+span]
                     + 64'(model_dims[lo]) * 64'(model_dims[mid])
                       * 64'(model_dims[lo+span]);
               if (trial < best) best = trial;
            end
            span_cost[lo][lo+span] = best & ((64'd1 << COST_W) - 64'd1);
         end
      end
      return span_cost[0][n-1][COST_W-1:0];
   endfunction

   task automatic model_accept(logic [FIELD_W-1:0] dim, logic last);
      chain_result_type res;
      if (model_count < MAX_DIMS) begin
         model_dims[model_count] = dim[DIM_BITS-1:0];
         model_count++;
      end else begin
         model_overflow = 1'b1;
      end
      if (last) begin
         res.cost     = least_mults(model_count);
         res.too_many = model_overflow;
         pending_costs.push_back(res);
         if (model_overflow) truncated_chains++;
         model_count    = 0;
         model_overflow = 1'b0;
      end
   endtask

   task automatic send_dim(logic [FIELD_W-1:0] dim, logic last);
      if (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(19, 1)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_dimension <= dim;
      req_last_dim  <= last;
      do @(posedge clock); while (req_ready !== 1'b1);
      model_accept(dim, last);
      items_sent++;
      if (last) chains_sent++;
   endtask

   task automatic send_chain(logic [FIELD_W-1:0] dims[$]);
      for (int i = 0; i < dims.size(); i++) send_dim(dims[i], i == dims.size() - 1);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_costs.size() != 0) @(posedge clock);
   endtask

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      if (errors <= MAX_REPORTS)
         $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
   endtask

   function automatic logic [FIELD_W-1:0] random_dim(dim_style_type style);
      case (style)
         DIMS_SMALL: return FIELD_W'($urandom_range(50, 1));
         DIMS_FULL:  return FIELD_W'($urandom_range(65535, 0));
         default: begin
            case ($urandom_range(3, 0))
               0:       return '0;
               1:       return FIELD_W'(1);
               2:       return '1;
               default: return FIELD_W'(16'h8000 >> $urandom_range(15, 0));
            endcase
         end
      endcase
   endfunction

   task automatic test_short_chains();
      logic [FIELD_W-1:0] dims[$];
      dims = {16'hFFFF};
      send_chain(dims);
      dims = {16'd5, 16'd7};
      send_chain(dims);
      settle();
   endtask

   task automatic test_textbook_chain();
      logic [FIELD_W-1:0] dims[$];
      dims = {16'd40, 16'd20, 16'd30, 16'd10, 16'd30};
      send_chain(dims);
      settle();
   endtask

   // full store of maximal dimensions, closing dimension dropped
   task automatic test_store_full();
      logic [FIELD_W-1:0] dims[$];
      repeat (MAX_DIMS + 1) dims.push_back('1);
      send_chain(dims);
      settle();
   endtask

   task automatic send_random_chain();
      logic [FIELD_W-1:0] dims[$];
      int                 len;
      int                 pick;
      dim_style_type      style;
      pick = $urandom_range(99, 0);
      if (pick < 55)      len = $urandom_range(6, 1);
      else if (pick < 85) len = $urandom_range(12, 7);
      else if (pick < 94) len = $urandom_range(16, 13);
      else                len = $urandom_range(MAX_DIMS + 4, MAX_DIMS + 1);
      pick = $urandom_range(9, 0);
      style = pick < 4 ? DIMS_SMALL : (pick < 8 ? DIMS_FULL : DIMS_CORNER);
      repeat (len) dims.push_back($urandom_range(7, 0) == 0 ?
                                  random_dim(DIMS_CORNER) : random_dim(style));
      send_chain(dims);
   endtask

   task automatic test_random_chains();
      int chain_no;
      chain_no = 0;
      while (items_sent < ITEM_TARGET - QUIET_ITEMS) begin
         if (chain_no % 25 == 0) begin
            case ($urandom_range(2, 0))
               0:       idle_pct = 0;
               1:       idle_pct = 15;
               default: idle_pct = 40;
            endcase
         end
         send_random_chain();
         chain_no++;
      end
      settle();
   endtask

   task automatic test_quiet_tail();
      idle_pct = 0;
      while (items_sent < ITEM_TARGET) send_random_chain();
      settle();
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (idle_pct > 0 && $urandom_range(99, 0) < idle_pct / 2) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(19, 1)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_results
      chain_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         results_seen++;
         if (pending_costs.size() == 0) begin
            report_mismatch("result with no chain pending, min_cost",
                            64'(rsp_min_cost), 64'(0));
         end else begin
            want = pending_costs.pop_front();
            if (rsp_min_cost !== want.cost)
               report_mismatch("min_cost", 64'(rsp_min_cost), 64'(want.cost));
            if (rsp_too_many !== want.too_many)
               report_mismatch("too_many", 64'(rsp_too_many), 64'(want.too_many));
         end
      end
   end

   initial begin
      #20_000_000;
      $display("matrix_chain_min_cost_top_test: done, errors");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_short_chains();
      test_textbook_chain();
      test_store_full();
      test_random_chains();
      test_quiet_tail();
      repeat (100) @(posedge clock);
      $display("Sent %0d dimensions in %0d chains (%0d truncated), checked %0d results.",
               items_sent, chains_sent, truncated_chains, results_seen);
      $display("%0d mismatches", errors);
      if (errors == 0) begin
         $display("matrix_chain_min_cost_top_test: done, clean");
      end else begin
         $display("matrix_chain_min_cost_top_test: done, errors");
      end
      $finish;
   end

endmodule
